// ===== hdl/tree_lca_euler_sparse_table_macros.svh =====
// Assertion macros shared by the checker.
`ifndef TREE_LCA_EULER_SPARSE_TABLE_MACROS_SVH
`define TREE_LCA_EULER_SPARSE_TABLE_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define TLCA_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// Next-cycle implication.
`define TLCA_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`endif

// ===== hdl/tlca_pkg.sv =====
// ----------------------------------------------------------------------------
// tlca_pkg
// Shared codes and control types for the LCA engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tlca_pkg;
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_EDGE  = 2'd1;
    localparam logic [1:0] KIND_BUILD = 2'd2;
    localparam logic [1:0] KIND_QUERY = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNREACH  = 2'd1;
    localparam logic [1:0] ST_UNBUILT  = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLR_HEAD,    // clear one adjacency head at sweep index
        OP_EDGE_RD,     // read heads of both endpoints
        OP_EDGE_W1,     // write first directed slot
        OP_EDGE_W2,     // write second directed slot
        OP_FV_CLR,      // clear one first-visit entry at sweep index
        OP_ROOT,        // push root
        OP_TOP_RD,      // read top frame
        OP_EDGE_LOOK,   // read edge slot of top cursor
        OP_EDGE_USE,    // update cursor, read target info
        OP_PUSH,        // push child
        OP_POP,         // pop frame
        OP_PARENT_RD,   // read new top for tour append
        OP_PARENT_APP,  // append parent to tour
        OP_SP_RD,       // read two sparse-table entries
        OP_SP_LVL,      // read their levels
        OP_SP_WR,       // write shallower
        OP_Q_FV,        // read first visits
        OP_Q_TAB,       // read first table entry
        OP_Q_LVL,       // read second table entry
        OP_Q_DONE       // read levels of both entries; answer chosen from them
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [11:0] idx;     // sweep index / sparse start position
        logic [3:0]  lvl;     // sparse level
    } cmd_t;

    typedef struct packed {
        logic        stack_empty;
        logic        cursor_end;
        logic        child_ok;
        logic        edge_full;
        logic        edge_bad;
        logic        q_ok;
        logic        tables_ready;
        logic [12:0] tour_len;
    } stat_t;
endpackage

// ===== hdl/tlca_datapath.sv =====
// ----------------------------------------------------------------------------
// tlca_datapath
// Memories, stack, tour and sparse-table datapath for the LCA engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tlca_datapath #(
    parameter int MAX_NODES    = 1024,
    parameter int TABLE_LEVELS = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tlca_pkg::cmd_t     cmd,
    input  logic [9:0]         root_node,
    input  logic [9:0]         node_a,
    input  logic [9:0]         node_b,
    input  logic [1:0]         kind,
    output tlca_pkg::stat_t    stat,
    output logic [9:0]         ancestor,
    output logic [1:0]         status
);
    localparam int NW = $clog2(MAX_NODES);
    localparam int EW = NW + 1;
    localparam int TW = NW + 1;
    localparam int LW = $clog2(TABLE_LEVELS);
    localparam int TAB_D = TABLE_LEVELS * 2 * MAX_NODES;
    localparam int TABW = $clog2(TAB_D);
    localparam logic [EW:0] NO_EDGE = (EW+1)'(2 * MAX_NODES);
    localparam logic [TW:0] UNSEEN  = (TW+1)'(2 * MAX_NODES);

    // Memories.
    logic [EW:0]  head_mem  [MAX_NODES];
    logic [NW-1:0] tgt_mem  [2*MAX_NODES];
    logic [EW:0]  link_mem  [2*MAX_NODES];
    logic [TW:0]  fv_mem    [MAX_NODES];
    logic [NW-1:0] lvl_mem  [MAX_NODES];
    logic [NW-1:0] stk_node [MAX_NODES];
    logic [EW:0]  stk_cur   [MAX_NODES];
    logic [NW-1:0] tab_mem  [TAB_D];

    logic [EW:0]  fill_reg;
    logic [TW:0]  tour_reg;
    logic         ready_reg;
    logic [NW:0]  sp_reg;
    logic [NW-1:0] top_node_reg;
    logic [EW:0]  top_cur_reg;
    logic [NW-1:0] tgt_reg;
    logic [EW:0]  link_reg;
    logic [TW:0]  tfv_reg;
    logic [NW-1:0] top_lvl_reg;
    logic [EW:0]  ha_reg, hb_reg;
    logic [NW-1:0] ea_reg, eb_reg;
    logic [NW-1:0] sa_reg, sb_reg;
    logic [NW-1:0] la_reg, lb_reg;
    logic [TW:0]  fa_reg, fb_reg;
    logic [TW:0]  qy_reg;
    logic [LW-1:0] qt_reg;
    logic         efull_reg;
    logic         nodes_ok;

    assign nodes_ok = (32'(node_a) < MAX_NODES) && (32'(node_b) < MAX_NODES);

    // Floor log with saturation.
    function automatic logic [LW-1:0] flog(input logic [TW:0] v);
        logic [LW-1:0] t;
        t = '0;
        for (int k = 1; k <= TW; k++)
            if ((v >> k) != 0)
                t = (k > TABLE_LEVELS - 1) ? LW'(TABLE_LEVELS - 1) : LW'(k);
        return t;
    endfunction

    function automatic logic [TABW-1:0] taddr(input logic [LW-1:0] l,
                                              input logic [TW:0] p);
        return TABW'(32'(l) * 2 * MAX_NODES + 32'(p));
    endfunction

    logic [TW:0] qlo, qhi, qspan, qb;
    logic [LW-1:0] qt;
    assign qlo   = (fa_reg > fb_reg) ? fb_reg : fa_reg;
    assign qhi   = (fa_reg > fb_reg) ? fa_reg : fb_reg;
    assign qspan = qhi - qlo + 1'b1;
    assign qt    = flog(qspan);
    assign qb    = qy_reg + 1'b1 - (TW+1)'(1 << qt_reg);

    logic [TW:0] sp_half;
    assign sp_half = (TW+1)'(1 << (cmd.lvl - 1'b1));

    // Memory writes and registers without reset.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            tlca_pkg::OP_CLR_HEAD: head_mem[cmd.idx[NW-1:0]] <= NO_EDGE;
            tlca_pkg::OP_FV_CLR:   fv_mem[cmd.idx[NW-1:0]] <= UNSEEN;
            tlca_pkg::OP_EDGE_RD:
            begin
                ha_reg <= head_mem[node_a[NW-1:0]];
                hb_reg <= head_mem[node_b[NW-1:0]];
            end
            tlca_pkg::OP_EDGE_W1:
            begin
                tgt_mem[fill_reg[EW-1:0]]  <= node_b[NW-1:0];
                link_mem[fill_reg[EW-1:0]] <= ha_reg;
                head_mem[node_a[NW-1:0]]   <= fill_reg;
                // Second endpoint may equal first: reread its head.
                if (node_a == node_b)
                    hb_reg <= fill_reg;
            end
            tlca_pkg::OP_EDGE_W2:
            begin
                tgt_mem[fill_reg[EW-1:0]]  <= node_a[NW-1:0];
                link_mem[fill_reg[EW-1:0]] <= hb_reg;
                head_mem[node_b[NW-1:0]]   <= fill_reg;
            end
            tlca_pkg::OP_ROOT:
            begin
                lvl_mem[root_node[NW-1:0]] <= '0;
                fv_mem[root_node[NW-1:0]]  <= '0;
                tab_mem[TABW'(0)]          <= root_node[NW-1:0];
                stk_node[0]                <= root_node[NW-1:0];
                stk_cur[0]                 <= head_mem[root_node[NW-1:0]];
            end
            tlca_pkg::OP_TOP_RD:
            begin
                top_node_reg <= stk_node[NW'(sp_reg - 1'b1)];
                top_cur_reg  <= stk_cur[NW'(sp_reg - 1'b1)];
            end
            tlca_pkg::OP_EDGE_LOOK:
            begin
                tgt_reg     <= tgt_mem[top_cur_reg[EW-1:0]];
                link_reg    <= link_mem[top_cur_reg[EW-1:0]];
                top_lvl_reg <= lvl_mem[top_node_reg];
            end
            tlca_pkg::OP_EDGE_USE:
            begin
                stk_cur[NW'(sp_reg - 1'b1)] <= link_reg;
                tfv_reg     <= fv_mem[tgt_reg];
                ea_reg      <= tgt_reg;
            end
            tlca_pkg::OP_PUSH:
            begin
                lvl_mem[ea_reg] <= top_lvl_reg + 1'b1;
                fv_mem[ea_reg]  <= tour_reg;
                if (tour_reg < (TW+1)'(2 * MAX_NODES))
                    tab_mem[TABW'(tour_reg)] <= ea_reg;
                stk_node[sp_reg[NW-1:0]] <= ea_reg;
                stk_cur[sp_reg[NW-1:0]]  <= head_mem[ea_reg];
            end
            tlca_pkg::OP_PARENT_RD:
                eb_reg <= stk_node[NW'(sp_reg - 1'b1)];
            tlca_pkg::OP_PARENT_APP:
                if (tour_reg < (TW+1)'(2 * MAX_NODES))
                    tab_mem[TABW'(tour_reg)] <= eb_reg;
            tlca_pkg::OP_SP_RD:
            begin
                sa_reg <= tab_mem[taddr(LW'(cmd.lvl - 1'b1), (TW+1)'(cmd.idx))];
                sb_reg <= tab_mem[taddr(LW'(cmd.lvl - 1'b1),
                                        (TW+1)'(cmd.idx) + sp_half)];
            end
            tlca_pkg::OP_SP_LVL:
            begin
                la_reg <= lvl_mem[sa_reg];
                lb_reg <= lvl_mem[sb_reg];
            end
            tlca_pkg::OP_SP_WR:
                tab_mem[taddr(LW'(cmd.lvl), (TW+1)'(cmd.idx))] <=
                    (la_reg < lb_reg) ? sa_reg : sb_reg;
            tlca_pkg::OP_Q_FV:
            begin
                fa_reg <= fv_mem[node_a[NW-1:0]];
                fb_reg <= fv_mem[node_b[NW-1:0]];
            end
            tlca_pkg::OP_Q_TAB:
            begin
                qy_reg <= qhi;
                qt_reg <= qt;
                sa_reg <= tab_mem[taddr(qt, qlo)];
            end
            tlca_pkg::OP_Q_LVL:
            begin
                sb_reg <= tab_mem[taddr(qt_reg, qb)];
            end
            default: ;
        endcase
        if (cmd.op == tlca_pkg::OP_Q_DONE)
        begin
            la_reg <= lvl_mem[sa_reg];
            lb_reg <= lvl_mem[sb_reg];
        end
    end

    // Control registers with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            tour_reg  <= '0;
            ready_reg <= 1'b0;
            sp_reg    <= '0;
        end
        else
        begin
            case (cmd.op)
                tlca_pkg::OP_CLR_HEAD:
                begin
                    fill_reg  <= '0;
                    ready_reg <= 1'b0;
                end
                tlca_pkg::OP_EDGE_RD: ready_reg <= 1'b0;
                tlca_pkg::OP_EDGE_W1, tlca_pkg::OP_EDGE_W2: fill_reg <= fill_reg + 1'b1;
                tlca_pkg::OP_FV_CLR:
                begin
                    tour_reg  <= '0;
                    ready_reg <= 1'b1;
                    sp_reg    <= '0;
                end
                tlca_pkg::OP_ROOT:
                begin
                    tour_reg <= (TW+1)'(1);
                    sp_reg   <= (NW+1)'(1);
                end
                tlca_pkg::OP_PUSH:
                begin
                    if (tour_reg < (TW+1)'(2 * MAX_NODES))
                        tour_reg <= tour_reg + 1'b1;
                    sp_reg <= sp_reg + 1'b1;
                end
                tlca_pkg::OP_POP: sp_reg <= sp_reg - 1'b1;
                tlca_pkg::OP_PARENT_APP:
                    if (tour_reg < (TW+1)'(2 * MAX_NODES))
                        tour_reg <= tour_reg + 1'b1;
                default: ;
            endcase
        end
    end

    // Status to controller.
    always_comb
    begin
        stat.stack_empty  = (sp_reg == '0);
        stat.cursor_end   = (top_cur_reg >= NO_EDGE);
        stat.child_ok     = (tfv_reg == UNSEEN) && (sp_reg < (NW+1)'(MAX_NODES));
        stat.edge_full    = (fill_reg + 2'd2) > (EW+1)'(2 * MAX_NODES);
        stat.edge_bad     = !nodes_ok;
        stat.q_ok         = nodes_ok && (fa_reg != UNSEEN) && (fb_reg != UNSEEN);
        stat.tables_ready = ready_reg;
        stat.tour_len     = 13'(tour_reg);
    end

    // The store must be judged full before the edge word fills it.
    always_ff @(posedge clk)
    begin
        if (cmd.op == tlca_pkg::OP_EDGE_RD)
            efull_reg <= stat.edge_full;
    end

    // Result word.
    always_comb
    begin
        ancestor = '0;
        status   = tlca_pkg::ST_OK;
        case (kind)
            tlca_pkg::KIND_EDGE:
                if (!nodes_ok) status = tlca_pkg::ST_UNREACH;
                else if (efull_reg) status = tlca_pkg::ST_FULL;
            tlca_pkg::KIND_QUERY:
                if (!ready_reg) status = tlca_pkg::ST_UNBUILT;
                else if (!stat.q_ok) status = tlca_pkg::ST_UNREACH;
                else ancestor = 10'((la_reg < lb_reg) ? sa_reg : sb_reg);
            default: ;
        endcase
    end
endmodule

// ===== hdl/tlca_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlca_ctrl
// Sequencer for clear, edge insert, build and query.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tlca_ctrl #(
    parameter int MAX_NODES    = 1024,
    parameter int TABLE_LEVELS = 12
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      kind,
    output logic [1:0]      kind_q,
    output logic            out_valid,
    input  logic            out_ready,
    input  tlca_pkg::stat_t stat,
    output tlca_pkg::cmd_t  cmd
);
    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_CLR, S_E_RD, S_E_W1, S_E_W2, S_B_CLR, S_B_ROOT,
        S_W_TOP, S_W_LOOK, S_W_USE, S_W_DEC, S_W_POP, S_W_PRD, S_W_PAPP,
        S_T_RD, S_T_LVL, S_T_WR, S_Q_FV, S_Q_TAB, S_Q_LVL, S_Q_DONE,
        S_Q_WAIT, S_RESP
    } state_t;

    state_t       state_reg;
    logic [11:0]  idx_reg;
    logic [3:0]   lvl_reg;
    logic [1:0]   kind_reg;
    logic [12:0]  win;

    assign kind_q   = kind_reg;
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_RESP);
    assign win      = 13'(idx_reg) + (13'(1) << lvl_reg);

    always_comb
    begin
        cmd.idx = idx_reg;
        cmd.lvl = lvl_reg;
        case (state_reg)
            S_INIT:   cmd.op = tlca_pkg::OP_CLR_HEAD;
            S_CLR:    cmd.op = tlca_pkg::OP_CLR_HEAD;
            S_E_RD:   cmd.op = tlca_pkg::OP_EDGE_RD;
            S_E_W1:   cmd.op = tlca_pkg::OP_EDGE_W1;
            S_E_W2:   cmd.op = tlca_pkg::OP_EDGE_W2;
            S_B_CLR:  cmd.op = tlca_pkg::OP_FV_CLR;
            S_B_ROOT: cmd.op = tlca_pkg::OP_ROOT;
            S_W_TOP:  cmd.op = tlca_pkg::OP_TOP_RD;
            S_W_LOOK: cmd.op = tlca_pkg::OP_EDGE_LOOK;
            S_W_USE:  cmd.op = tlca_pkg::OP_EDGE_USE;
            S_W_POP:  cmd.op = tlca_pkg::OP_POP;
            S_W_PRD:  cmd.op = tlca_pkg::OP_PARENT_RD;
            S_W_PAPP: cmd.op = tlca_pkg::OP_PARENT_APP;
            S_T_RD:   cmd.op = tlca_pkg::OP_SP_RD;
            S_T_LVL:  cmd.op = tlca_pkg::OP_SP_LVL;
            S_T_WR:   cmd.op = tlca_pkg::OP_SP_WR;
            S_Q_FV:   cmd.op = tlca_pkg::OP_Q_FV;
            S_Q_TAB:  cmd.op = tlca_pkg::OP_Q_TAB;
            S_Q_LVL:  cmd.op = tlca_pkg::OP_Q_LVL;
            S_Q_DONE: cmd.op = tlca_pkg::OP_Q_DONE;
            default:  cmd.op = tlca_pkg::OP_NONE;
        endcase
        if (state_reg == S_W_DEC && stat.child_ok)
            cmd.op = tlca_pkg::OP_PUSH;
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            idx_reg   <= '0;
            lvl_reg   <= '0;
            kind_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                // Empty every adjacency list once after reset.
                S_INIT:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (32'(idx_reg) == MAX_NODES - 1)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                    if (in_valid)
                    begin
                        kind_reg <= kind;
                        idx_reg  <= '0;
                        case (kind)
                            tlca_pkg::KIND_CLEAR: state_reg <= S_CLR;
                            tlca_pkg::KIND_EDGE:  state_reg <= S_E_RD;
                            tlca_pkg::KIND_BUILD: state_reg <= S_B_CLR;
                            default:              state_reg <= S_Q_FV;
                        endcase
                    end
                S_CLR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (32'(idx_reg) == MAX_NODES - 1)
                        state_reg <= S_RESP;
                end
                S_E_RD:
                    state_reg <= (stat.edge_bad || stat.edge_full) ? S_RESP : S_E_W1;
                S_E_W1: state_reg <= S_E_W2;
                S_E_W2: state_reg <= S_RESP;
                S_B_CLR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (32'(idx_reg) == MAX_NODES - 1)
                        state_reg <= S_B_ROOT;
                end
                S_B_ROOT: state_reg <= S_W_TOP;
                S_W_TOP:
                    if (stat.stack_empty)
                    begin
                        lvl_reg <= 4'd1;
                        idx_reg <= '0;
                        state_reg <= S_T_RD;
                    end
                    else
                        state_reg <= S_W_LOOK;
                S_W_LOOK: state_reg <= stat.cursor_end ? S_W_POP : S_W_USE;
                S_W_USE:  state_reg <= S_W_DEC;
                S_W_DEC:  state_reg <= S_W_TOP;
                S_W_POP:  state_reg <= S_W_PRD;
                S_W_PRD:  state_reg <= stat.stack_empty ? S_W_TOP : S_W_PAPP;
                S_W_PAPP: state_reg <= S_W_TOP;
                S_T_RD:
                    if (32'(lvl_reg) >= TABLE_LEVELS || win > stat.tour_len)
                        state_reg <= S_RESP;
                    else
                        state_reg <= S_T_LVL;
                S_T_LVL:  state_reg <= S_T_WR;
                S_T_WR:
                begin
                    if (win + 1'b1 > stat.tour_len)
                    begin
                        idx_reg <= '0;
                        lvl_reg <= lvl_reg + 1'b1;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                    state_reg <= S_T_RD;
                end
                S_Q_FV:   state_reg <= S_Q_TAB;
                S_Q_TAB:  state_reg <= S_Q_LVL;
                S_Q_LVL:  state_reg <= S_Q_DONE;
                S_Q_DONE: state_reg <= S_Q_WAIT;
                S_Q_WAIT: state_reg <= S_RESP;
                S_RESP:   if (out_ready) state_reg <= S_IDLE;
                default:  state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hdl/tree_lca_euler_sparse_table.sv =====
// ----------------------------------------------------------------------------
// tree_lca_euler_sparse_table
// Lowest-common-ancestor engine using an Euler tour and a sparse table.
// ----------------------------------------------------------------------------
// Channel  Signals                               Direction
// input    in_valid/in_ready kind node_a node_b  in
// output   out_valid/out_ready ancestor status   out
// config   cfg_we cfg_wdata (root_node)          in
// A query reads first visits, two table entries and their levels one after
// another; an edge reads both heads, then writes two slots unless dropped.
// After reset, a sweep empties the adjacency heads with in_ready low. Clear
// sweeps all adjacency heads. Build sweeps first visits, walks the tree (top
// read, edge look, edge use, push decision per edge slot examined; top read, edge
// look, pop, parent read, parent append per return to a parent), then fills
// each sparse-table entry. One word is handled at a time; a stalled output holds.
`timescale 1ns / 1ps
module tree_lca_euler_sparse_table #(
    parameter int MAX_NODES    = 1024,
    parameter int TABLE_LEVELS = 12
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [9:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] kind,
    input  logic [9:0] node_a,
    input  logic [9:0] node_b,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [9:0] ancestor,
    output logic [1:0] status
);
    tlca_pkg::cmd_t  cmd;
    tlca_pkg::stat_t stat;
    logic [9:0] root_reg;
    logic [1:0] kind_q;
    logic [9:0] a_reg, b_reg;

    // Root register and captured operands.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            root_reg <= '0;
        else if (cfg_we)
            root_reg <= cfg_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            a_reg <= node_a;
            b_reg <= node_b;
        end
    end

    tlca_ctrl #(.MAX_NODES(MAX_NODES), .TABLE_LEVELS(TABLE_LEVELS)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .kind_q(kind_q), .out_valid(out_valid),
        .out_ready(out_ready), .stat(stat), .cmd(cmd)
    );

    tlca_datapath #(.MAX_NODES(MAX_NODES), .TABLE_LEVELS(TABLE_LEVELS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .root_node(root_reg),
        .node_a(a_reg), .node_b(b_reg), .kind(kind_q), .stat(stat),
        .ancestor(ancestor), .status(status)
    );
endmodule

// ===== hdl/tlca_checker.sv =====
// ----------------------------------------------------------------------------
// tlca_checker
// Port-level checks for the LCA engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tree_lca_euler_sparse_table_macros.svh"
module tlca_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [9:0] ancestor,
    input logic [1:0] status
);
    `TLCA_ASSERT_IMP(a_excl, clk, rst_n, out_valid, !in_ready)
    `TLCA_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status))
    `TLCA_ASSERT_IMP(a_fail_zero, clk, rst_n, out_valid && status != tlca_pkg::ST_OK, ancestor == 10'd0)
    `TLCA_ASSERT_NXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready)
endmodule

bind tree_lca_euler_sparse_table tlca_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .ancestor(ancestor), .status(status)
);
